/* rtl/dprx_pkg.sv */
// ----------------------------------------------------------------------------
// dprx_pkg
// Shared types, character codes and hex digit decoding for the debug packet
// receive deframer.
// ----------------------------------------------------------------------------
package dprx_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ACK   = 8'h2B;
  localparam logic [7:0] CH_NACK  = 8'h2D;

  localparam int LEN_W    = 11;
  localparam int LEN_MAX  = 2047;
  localparam int TDATA_W  = 40;
  localparam int TUSER_W  = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_GOOD = 2'd2,
    KIND_BAD  = 2'd3
  } dprx_kind_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_DATA = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } dprx_phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } dprx_item_t;

  typedef struct packed {
    logic             is_hex;
    logic [3:0]       value;
  } dprx_hex_t;

  function automatic dprx_hex_t hex_decode(input logic [7:0] b);
    dprx_hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.value = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

/* rtl/dprx_in_stage.sv */
// ----------------------------------------------------------------------------
// dprx_in_stage
// Input register: captures one received byte and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module dprx_in_stage
  import dprx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  output dprx_item_t item,
  input  logic       item_take
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_tready = !vld_r || item_take;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign item.vld     = vld_r;
  assign item.rx_byte = byte_r;

endmodule

/* rtl/dprx_core.sv */
// ----------------------------------------------------------------------------
// dprx_core
// Frame state, running sum and length count, and the result register.
// ----------------------------------------------------------------------------
module dprx_core
  import dprx_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dprx_item_t         item,
  output logic               item_take,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser
);

  localparam int LenCapI = (MAX_LEN > LEN_MAX) ? LEN_MAX : MAX_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCapI);

  dprx_phase_t      phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [3:0]       high_r, high_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;

  logic             ovld_r;
  dprx_kind_t       kind_r, kind_nxt;
  logic [7:0]       pb_r, pb_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       csum_r, csum_nxt;
  logic [7:0]       rsum_r, rsum_nxt;

  dprx_hex_t        hex;
  logic [7:0]       b;

  assign b         = item.rx_byte;
  assign hex       = hex_decode(b);
  assign item_take = item.vld && (!ovld_r || out_tready);

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    high_nxt  = high_r;
    count_nxt = count_r;
    kind_nxt  = KIND_NONE;
    pb_nxt    = 8'd0;
    len_nxt   = '0;
    csum_nxt  = 8'd0;
    rsum_nxt  = 8'd0;
    case (phase_r)
      PH_HUNT: begin
        if (b == CH_START) begin
          sum_nxt   = 8'd0;
          count_nxt = '0;
          high_nxt  = 4'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (b == CH_HASH) begin
          phase_nxt = PH_HIGH;
        end else begin
          sum_nxt  = sum_r + b;
          if (count_r < LEN_CAP) begin
            count_nxt = count_r + LEN_W'(1);
          end
          kind_nxt = KIND_DATA;
          pb_nxt   = b;
        end
      end
      PH_HIGH: begin
        if (hex.is_hex) begin
          high_nxt  = hex.value;
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        if (hex.is_hex) begin
          rsum_nxt  = {high_r, hex.value};
          csum_nxt  = sum_r;
          len_nxt   = count_r;
          kind_nxt  = ({high_r, hex.value} == sum_r) ? KIND_GOOD : KIND_BAD;
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 8'd0;
      high_r  <= 4'd0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (item_take) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        high_r  <= high_nxt;
        count_r <= count_nxt;
        ovld_r  <= 1'b1;
      end else if (out_tready) begin
        ovld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      kind_r <= kind_nxt;
      pb_r   <= pb_nxt;
      len_r  <= len_nxt;
      csum_r <= csum_nxt;
      rsum_r <= rsum_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {5'd0, rsum_r, csum_r, len_r, pb_r};

endmodule

/* rtl/debug_packet_rx_deframer.sv */
// ----------------------------------------------------------------------------
// debug_packet_rx_deframer
// Receive deframer for $payload#hh debug packets.
//
// The in_ channel carries one received byte per transfer. Every accepted
// byte yields exactly one transfer on the out_ channel: out_tuser gives the
// kind (nothing, payload byte, frame good - send ack, frame bad - send nack)
// and out_tdata the payload byte, frame length and both checksums.
// Bytes before '$' are dropped; after '#' two hex digits of either case give
// the received sum and non-hex bytes are skipped. The length count stops at
// MAX_LEN (at most 2047).
// Path: a byte accepted on in_ is loaded into the input register, and the
// state update moves it into the result register, which drives out_.
// Throughput: one byte per cycle while out_ does not stall, set by the
// combinational state update between the two registers.
// Reset: both registers empty, frame state hunting for '$'.
// When the receiver stalls, the result holds; one more byte fills the input
// register, then in_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module debug_packet_rx_deframer
  import dprx_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] rx_byte
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [18:8] frame_length,
                                         // [26:19] computed_sum, [34:27] received_sum
  output logic [TUSER_W-1:0] out_tuser   // [1:0] kind
);

  dprx_item_t item;
  logic       item_take;

  dprx_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .item      (item),
    .item_take (item_take)
  );

  dprx_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/dprx_checker.sv */
// ----------------------------------------------------------------------------
// dprx_checker
// Port-level checks for the debug packet receive deframer.
// ----------------------------------------------------------------------------
module dprx_checker
  import dprx_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata,
  input logic [TUSER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata[7:0] == 8'd0)
    else $error("payload byte set outside a payload result");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_NONE || out_tuser == KIND_DATA)
      |-> out_tdata[TDATA_W-1:8] == '0)
    else $error("frame fields set outside a frame end");

  a_good_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_GOOD |-> out_tdata[26:19] == out_tdata[34:27])
    else $error("ack with mismatched sums");

  a_bad_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_BAD |-> out_tdata[26:19] != out_tdata[34:27])
    else $error("nack with matching sums");

endmodule

bind debug_packet_rx_deframer dprx_checker u_dprx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/tb_debug_packet_rx_deframer.sv */
// ----------------------------------------------------------------------------
// tb_debug_packet_rx_deframer
// Self-checking bench for the $payload#hh debug packet deframer.
//
// Received bytes go in on the in_ stream. Every accepted byte runs through a
// behavioural deframer here: hunting, payload summing, saturating length
// count, and the checksum digits with non-hex bytes skipped. That deframer
// queues one expected result per byte. A monitor takes each out_ transfer and
// compares kind, payload byte, length and both sums with the oldest entry.
// The run starts with directed frames, then a frame longer than the length
// cap, then random traffic. The random traffic is mostly well-formed frames,
// some of them with bad checksums or junk before each digit, with line noise
// and cut-off frames mixed in. Both stream sides stall at random in the
// first two phases, with different rates in each; the last has no stalls.
// ----------------------------------------------------------------------------
module tb_debug_packet_rx_deframer
  import dprx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = 1024;
  localparam int LEN_CAP     = (MAX_LEN > LEN_MAX) ? LEN_MAX : MAX_LEN;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    dprx_kind_t       kind;
    logic [7:0]       payload;
    logic [LEN_W-1:0] len;
    logic [7:0]       csum;
    logic [7:0]       rsum;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;

  frame_result_t pending_results[$];

  dprx_phase_t      rx_phase = PH_HUNT;
  logic [7:0]       acc_sum  = '0;
  logic [3:0]       hi_nib   = '0;
  logic [LEN_W-1:0] acc_len  = '0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int sent_count   = 0;
  int error_count  = 0;
  int cycle_count  = 0;

  debug_packet_rx_deframer #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [4:0]    d;
    r      = '0;
    r.kind = KIND_NONE;
    d      = hex_digit(b);
    case (rx_phase)
      PH_HUNT: begin
        if (b == CH_START) begin
          acc_sum  = '0;
          acc_len  = '0;
          hi_nib   = '0;
          rx_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (b == CH_HASH) begin
          rx_phase = PH_HIGH;
        end else begin
          acc_sum = acc_sum + b;
          if (acc_len < LEN_CAP) acc_len = acc_len + 1'b1;
          r.kind    = KIND_DATA;
          r.payload = b;
        end
      end
      PH_HIGH: begin
        if (d[4]) begin
          hi_nib   = d[3:0];
          rx_phase = PH_LOW;
        end
      end
      default: begin
        if (d[4]) begin
          r.rsum   = {hi_nib, d[3:0]};
          r.csum   = acc_sum;
          r.len    = acc_len;
          r.kind   = (r.rsum == r.csum) ? KIND_GOOD : KIND_BAD;
          rx_phase = PH_HUNT;
        end
      end
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    sent_count++;
  endtask

  task automatic send_junk();
    logic [7:0] b;
    logic [4:0] d;
    do begin
      b = 8'($urandom_range(255));
      d = hex_digit(b);
    end while (d[4]);
    send_byte(b);
  endtask

  task automatic send_frame(input int len, input bit intact, input bit with_junk);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    sum = '0;
    send_byte(CH_START);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (b == CH_HASH) b = b ^ 8'h80;
      sum = sum + b;
      send_byte(b);
    end
    send_byte(CH_HASH);
    chk = intact ? sum : 8'($urandom_range(255));
    if (with_junk) send_junk();
    send_byte(nibble_to_ascii(chk[7:4], 1'($urandom_range(1))));
    if (with_junk) send_junk();
    send_byte(nibble_to_ascii(chk[3:0], 1'($urandom_range(1))));
  endtask

  task automatic test_directed_frames();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_HASH);
    send_byte(CH_ACK);
    // '$' inside payload is data; skip non-hex, '$' and '#' after the hash
    send_byte(CH_START);
    send_byte(CH_START);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_HASH);
    send_byte("g");
    send_byte(CH_START);
    send_byte(CH_HASH);
    send_byte("2");
    send_byte("z");
    send_byte("3");
    send_byte(CH_START);
    send_byte(8'hFB);
    send_byte(8'hFF);
    send_byte(CH_HASH);
    send_byte("F");
    send_byte("a");
    send_byte(CH_START);
    send_byte(CH_HASH);
    send_byte("0");
    send_byte("0");
    send_byte(CH_START);
    send_byte(8'h80);
    send_byte(CH_HASH);
    send_byte("9");
    send_byte("A");
  endtask

  task automatic test_length_saturation();
    send_frame(LEN_CAP + 6, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input int budget);
    int start;
    int pick;
    int len;
    start = sent_count;
    while (sent_count - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(99);
        len = (len < 85) ? $urandom_range(12) :
              (len < 97) ? $urandom_range(60, 13) : $urandom_range(200, 61);
        send_frame(len, $urandom_range(99) < 70, $urandom_range(99) < 15);
      end else if (pick < 93) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(CH_START);
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t    want;
    logic [LEN_W-1:0] got_len;
    logic [7:0]       got_payload, got_csum, got_rsum;
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got_payload = out_tdata[7:0];
      got_len     = out_tdata[18:8];
      got_csum    = out_tdata[26:19];
      got_rsum    = out_tdata[34:27];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind %0d payload %h len %0d csum %h rsum %h",
                   out_tuser, got_payload, got_len, got_csum, got_rsum);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind || got_payload != want.payload ||
            got_len != want.len || got_csum != want.csum || got_rsum != want.rsum) begin
          error_count++;
          if (error_count <= 10)
            $display("exp/got kind %0d/%0d pb %h/%h len %0d/%0d csum %h/%h rsum %h/%h",
                     want.kind, out_tuser, want.payload, got_payload, want.len, got_len,
                     want.csum, got_csum, want.rsum, got_rsum);
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 23;
    rcv_idle_pct = 54;
    test_directed_frames();
    test_length_saturation();
    test_random_traffic(195);

    snd_idle_pct = 54;
    rcv_idle_pct = 23;
    test_random_traffic(195);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(195);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
